// ===== rtl/core/scs_pkg.sv =====
// Shared types, constants and arithmetic helpers for the convection stencil.
// Used by the controller, the datapath and the top level.
`default_nettype none

package scs_pkg;

    localparam int MAX_SIZE_X  = 64;
    localparam int MAX_SIZE_Y  = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int PLANE_CELLS = MAX_SIZE_X * MAX_SIZE_Y;
    localparam int RAM_DEPTH   = 3 * PLANE_CELLS;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);

    localparam int XW       = 6;
    localparam int YW       = 6;
    localparam int ZW       = 16;
    localparam int SIZE_XYW = 7;
    localparam int INV_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IW   = 3;

    localparam int NTAP   = 13;
    localparam int TAP_W  = 4;
    localparam int NTERM  = 9;
    localparam int TERM_W = 4;

    localparam int SHIFT_DIFF  = 18;
    localparam int SHIFT_SCALE = 16;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int Q_W    = DATA_WIDTH + INV_W + 1;
    localparam int WIDE_W = (PROD_W + 1 > Q_W) ? PROD_W + 1 : Q_W;
    localparam int ACC_W  = DATA_WIDTH + 2;

    localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // neighbor taps around the center cell
    localparam logic [TAP_W-1:0] T_C     = 4'd0;
    localparam logic [TAP_W-1:0] T_XP    = 4'd1;
    localparam logic [TAP_W-1:0] T_XM    = 4'd2;
    localparam logic [TAP_W-1:0] T_YP    = 4'd3;
    localparam logic [TAP_W-1:0] T_YM    = 4'd4;
    localparam logic [TAP_W-1:0] T_ZP    = 4'd5;
    localparam logic [TAP_W-1:0] T_ZM    = 4'd6;
    localparam logic [TAP_W-1:0] T_XP_YM = 4'd7;
    localparam logic [TAP_W-1:0] T_XP_ZM = 4'd8;
    localparam logic [TAP_W-1:0] T_XM_YP = 4'd9;
    localparam logic [TAP_W-1:0] T_YP_ZM = 4'd10;
    localparam logic [TAP_W-1:0] T_XM_ZP = 4'd11;
    localparam logic [TAP_W-1:0] T_YM_ZP = 4'd12;

    typedef enum logic [CFG_IW-1:0] {
        CFG_INV_DX = 3'd0,
        CFG_INV_DY = 3'd1,
        CFG_INV_DZ = 3'd2,
        CFG_SIZE_X = 3'd3,
        CFG_SIZE_Y = 3'd4,
        CFG_SIZE_Z = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_SUM,
        PH_MUL1,
        PH_MUL2,
        PH_DIFF,
        PH_SCALE,
        PH_ACC
    } phase_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    typedef enum logic [1:0] {
        GRP_U,
        GRP_V,
        GRP_W
    } grp_t;

    typedef struct packed {
        logic             mem_we;
        logic             mem_re;
        logic [TAP_W-1:0] tap;
        logic [TERM_W-1:0] term;
        axis_t            axis;
        grp_t             grp;
        phase_t           phase;
        logic             out_load;
        logic [XW-1:0]    px;
        logic [YW-1:0]    py;
        logic [1:0]       slot;
    } scs_cmd_t;

    typedef struct packed {
        logic taps_ready;
    } scs_stat_t;

    // offset codes per tap: {dx, dy, dz}, 0 = -1, 1 = 0, 2 = +1
    function automatic logic [5:0] tap_ofs(input logic [TAP_W-1:0] tap);
        logic [5:0] r;
        case (tap)
            T_C:     r = {2'd1, 2'd1, 2'd1};
            T_XP:    r = {2'd2, 2'd1, 2'd1};
            T_XM:    r = {2'd0, 2'd1, 2'd1};
            T_YP:    r = {2'd1, 2'd2, 2'd1};
            T_YM:    r = {2'd1, 2'd0, 2'd1};
            T_ZP:    r = {2'd1, 2'd1, 2'd2};
            T_ZM:    r = {2'd1, 2'd1, 2'd0};
            T_XP_YM: r = {2'd2, 2'd0, 2'd1};
            T_XP_ZM: r = {2'd2, 2'd1, 2'd0};
            T_XM_YP: r = {2'd0, 2'd2, 2'd1};
            T_YP_ZM: r = {2'd1, 2'd2, 2'd0};
            T_XM_ZP: r = {2'd0, 2'd1, 2'd2};
            T_YM_ZP: r = {2'd1, 2'd0, 2'd2};
            default: r = {2'd1, 2'd1, 2'd1};
        endcase
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_add(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = (DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b);
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            return s[DATA_WIDTH] ? DMIN : DMAX;
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_wide(
        input logic signed [WIDE_W-1:0] x
    );
        logic [WIDE_W-DATA_WIDTH:0] hi;
        hi = x[WIDE_W-1:DATA_WIDTH-1];
        if ((&hi) || !(|hi))
            return x[DATA_WIDTH-1:0];
        return x[WIDE_W-1] ? DMIN : DMAX;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_acc(
        input logic signed [ACC_W-1:0] x
    );
        logic [ACC_W-DATA_WIDTH:0] hi;
        hi = x[ACC_W-1:DATA_WIDTH-1];
        if ((&hi) || !(|hi))
            return x[DATA_WIDTH-1:0];
        return x[ACC_W-1] ? DMIN : DMAX;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scs_ram.sv =====
// Generic single-port RAM, one write and one registered read per cycle, sharing one address.
// No dependencies.
`default_nettype none

module scs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/scs_ctrl.sv =====
// Controller: grid position, size registers, tap read and term sequencing,
// output handshake and cell index outputs. Depends on scs_pkg.
`default_nettype none

module scs_ctrl
    import scs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  scs_stat_t              stat,
    output scs_cmd_t               cmd,
    output logic [XW-1:0]          cell_x,
    output logic [YW-1:0]          cell_y,
    output logic [ZW-1:0]          cell_z,
    output logic                   last_cell
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_WAIT  = 10'b0000000100,
        S_SUM   = 10'b0000001000,
        S_MUL1  = 10'b0000010000,
        S_MUL2  = 10'b0000100000,
        S_DIFF  = 10'b0001000000,
        S_SCALE = 10'b0010000000,
        S_ACC   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_XYW-1:0] size_x_reg, size_y_reg;
    logic [ZW-1:0]       size_z_reg;
    logic [XW-1:0]       pos_x_reg, pos_x_next;
    logic [YW-1:0]       pos_y_reg, pos_y_next;
    logic [ZW-1:0]       pos_z_reg, pos_z_next;
    logic [1:0]          slot_reg, slot_next;
    logic [XW-1:0]       cur_x_reg;
    logic [YW-1:0]       cur_y_reg;
    logic [1:0]          cur_slot_reg;
    logic [XW-1:0]       pend_x_reg;
    logic [YW-1:0]       pend_y_reg;
    logic [ZW-1:0]       pend_z_reg;
    logic                pend_last_reg;
    logic [XW-1:0]       cell_x_reg;
    logic [YW-1:0]       cell_y_reg;
    logic [ZW-1:0]       cell_z_reg;
    logic                last_cell_reg;
    logic                out_valid_reg;
    logic [TAP_W-1:0]    rd_cnt_reg;
    logic [TERM_W-1:0]   term_reg;
    axis_t               axis_reg;
    grp_t                grp_reg;

    logic [SIZE_XYW-1:0] sx, sy;
    logic [ZW-1:0]       sz;
    logic [XW-1:0]       px;
    logic [YW-1:0]       py;
    logic [ZW-1:0]       pz;
    logic [1:0]          pslot;
    logic                accept, interior, is_last, out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // clamp sizes into the supported range
    always_comb
    begin
        if (size_x_reg < SIZE_XYW'(3))
            sx = SIZE_XYW'(3);
        else if (size_x_reg > SIZE_XYW'(MAX_SIZE_X))
            sx = SIZE_XYW'(MAX_SIZE_X);
        else
            sx = size_x_reg;
        if (size_y_reg < SIZE_XYW'(3))
            sy = SIZE_XYW'(3);
        else if (size_y_reg > SIZE_XYW'(MAX_SIZE_Y))
            sy = SIZE_XYW'(MAX_SIZE_Y);
        else
            sy = size_y_reg;
        sz = (size_z_reg < ZW'(3)) ? ZW'(3) : size_z_reg;
    end

    // a position beyond a shrunk size restarts that axis
    always_comb
    begin
        px    = ({1'b0, pos_x_reg} >= sx) ? '0 : pos_x_reg;
        py    = ({1'b0, pos_y_reg} >= sy) ? '0 : pos_y_reg;
        pz    = (pos_z_reg >= sz) ? '0 : pos_z_reg;
        pslot = (pos_z_reg >= sz) ? 2'd0 : slot_reg;
        interior = (px >= XW'(2)) && (py >= YW'(2)) && (pz >= ZW'(2));
        is_last  = ({1'b0, px} == sx - SIZE_XYW'(1)) && ({1'b0, py} == sy - SIZE_XYW'(1))
                && (pz == sz - ZW'(1));
    end

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        slot_next  = slot_reg;
        if (accept)
        begin
            pos_x_next = px;
            pos_y_next = py;
            pos_z_next = pz;
            slot_next  = pslot;
            if ({1'b0, px} + SIZE_XYW'(1) < sx)
                pos_x_next = px + XW'(1);
            else
            begin
                pos_x_next = '0;
                if ({1'b0, py} + SIZE_XYW'(1) < sy)
                    pos_y_next = py + YW'(1);
                else
                begin
                    pos_y_next = '0;
                    if ({1'b0, pz} + (ZW+1)'(1) < {1'b0, sz})
                    begin
                        pos_z_next = pz + ZW'(1);
                        slot_next  = (pslot == 2'd2) ? 2'd0 : pslot + 2'd1;
                    end
                    else
                    begin
                        pos_z_next = '0;
                        slot_next  = 2'd0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept && interior) state_next = S_READ;
            S_READ:  if (rd_cnt_reg == TAP_W'(NTAP - 1)) state_next = S_WAIT;
            S_WAIT:  if (stat.taps_ready) state_next = S_SUM;
            S_SUM:   state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_DIFF;
            S_DIFF:  state_next = S_SCALE;
            S_SCALE: state_next = S_ACC;
            S_ACC:   state_next = (grp_reg == GRP_W && axis_reg == AX_Z) ? S_DONE : S_SUM;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.mem_we   = accept;
        cmd.mem_re   = (state_reg == S_READ);
        cmd.tap      = rd_cnt_reg;
        cmd.term     = term_reg;
        cmd.axis     = axis_reg;
        cmd.grp      = grp_reg;
        cmd.out_load = (state_reg == S_DONE) && out_free;
        cmd.px       = (state_reg == S_IDLE) ? px : cur_x_reg;
        cmd.py       = (state_reg == S_IDLE) ? py : cur_y_reg;
        cmd.slot     = (state_reg == S_IDLE) ? pslot : cur_slot_reg;
        case (state_reg)
            S_SUM:   cmd.phase = PH_SUM;
            S_MUL1:  cmd.phase = PH_MUL1;
            S_MUL2:  cmd.phase = PH_MUL2;
            S_DIFF:  cmd.phase = PH_DIFF;
            S_SCALE: cmd.phase = PH_SCALE;
            S_ACC:   cmd.phase = PH_ACC;
            default: cmd.phase = PH_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_x_reg    <= SIZE_XYW'(64);
            size_y_reg    <= SIZE_XYW'(64);
            size_z_reg    <= ZW'(64);
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            slot_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            term_reg      <= '0;
            axis_reg      <= AX_X;
            grp_reg       <= GRP_U;
        end
        else
        begin
            state_reg <= state_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            slot_reg  <= slot_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SIZE_X: size_x_reg <= cfg_data[SIZE_XYW-1:0];
                    CFG_SIZE_Y: size_y_reg <= cfg_data[SIZE_XYW-1:0];
                    CFG_SIZE_Z: size_z_reg <= cfg_data[ZW-1:0];
                    default: ;
                endcase
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                rd_cnt_reg <= '0;
                term_reg   <= '0;
                axis_reg   <= AX_X;
                grp_reg    <= GRP_U;
            end
            else if (state_reg == S_READ)
                rd_cnt_reg <= rd_cnt_reg + TAP_W'(1);
            else if (state_reg == S_ACC)
            begin
                term_reg <= term_reg + TERM_W'(1);
                case (axis_reg)
                    AX_X: axis_reg <= AX_Y;
                    AX_Y: axis_reg <= AX_Z;
                    default:
                    begin
                        axis_reg <= AX_X;
                        case (grp_reg)
                            GRP_U:   grp_reg <= GRP_V;
                            GRP_V:   grp_reg <= GRP_W;
                            default: grp_reg <= GRP_U;
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg     <= px;
            cur_y_reg     <= py;
            cur_slot_reg  <= pslot;
            pend_x_reg    <= px - XW'(1);
            pend_y_reg    <= py - YW'(1);
            pend_z_reg    <= pz - ZW'(1);
            pend_last_reg <= is_last;
        end
        if (cmd.out_load)
        begin
            cell_x_reg    <= pend_x_reg;
            cell_y_reg    <= pend_y_reg;
            cell_z_reg    <= pend_z_reg;
            last_cell_reg <= pend_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_x    = cell_x_reg;
    assign cell_y    = cell_y_reg;
    assign cell_z    = cell_z_reg;
    assign last_cell = last_cell_reg;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> out_valid_reg)
        else $error("loaded result not presented");
    a_boundary_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !interior) |=> (state_reg == S_IDLE))
        else $error("boundary item started work");
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (rd_cnt_reg < TAP_W'(NTAP)))
        else $error("tap read counter overrun");
    a_last_term: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && grp_reg == GRP_W && axis_reg == AX_Z)
        |=> (state_reg == S_DONE && term_reg == TERM_W'(NTERM)))
        else $error("term sequence out of step");

endmodule

`default_nettype wire

// ===== rtl/core/scs_dpath.sv =====
// Datapath: plane stores, tap registers, shared term unit, accumulator and
// output result registers. Depends on scs_pkg and scs_ram.
`default_nettype none

module scs_dpath
    import scs_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IW-1:0]            cfg_index,
    input  wire logic [CFG_W-1:0]             cfg_data,
    input  wire logic signed [DATA_WIDTH-1:0] u_sample,
    input  wire logic signed [DATA_WIDTH-1:0] v_sample,
    input  wire logic signed [DATA_WIDTH-1:0] w_sample,
    input  scs_cmd_t                          cmd,
    output scs_stat_t                         stat,
    output logic signed [DATA_WIDTH-1:0]      conv_u,
    output logic signed [DATA_WIDTH-1:0]      conv_v,
    output logic signed [DATA_WIDTH-1:0]      conv_w
);

    logic [INV_W-1:0] inv_dx_reg, inv_dy_reg, inv_dz_reg;

    logic [5:0]        ofs;
    logic [XW-1:0]     ax;
    logic [YW-1:0]     ay;
    logic [2:0]        zsum;
    logic [1:0]        zs;
    logic [ADDR_W-1:0] addr;
    logic [DATA_WIDTH-1:0] rd_u, rd_v, rd_w;

    logic              cap_en_reg;
    logic [TAP_W-1:0]  cap_tap_reg;
    logic              taps_ready_reg;
    logic signed [DATA_WIDTH-1:0] tu_reg [NTAP];
    logic signed [DATA_WIDTH-1:0] tv_reg [NTAP];
    logic signed [DATA_WIDTH-1:0] tw_reg [NTAP];

    logic signed [DATA_WIDTH-1:0] a1, a2, b1, b2, c1, c2, d1, d2;
    logic signed [DATA_WIDTH-1:0] s1_reg, s2_reg, s3_reg, s4_reg;
    logic signed [PROD_W-1:0]     p1_reg, p2_reg;
    logic signed [WIDE_W-1:0]     diff;
    logic signed [WIDE_W-1:0]     diff_sh;
    logic signed [DATA_WIDTH-1:0] t_reg;
    logic signed [Q_W-1:0]        q_reg;
    logic signed [WIDE_W-1:0]     q_sh;
    logic signed [DATA_WIDTH-1:0] scaled;
    logic [INV_W-1:0]             inv_sel;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [DATA_WIDTH-1:0] res_u_reg, res_v_reg, res_w_reg;
    logic signed [DATA_WIDTH-1:0] conv_u_reg, conv_v_reg, conv_w_reg;

    // store address: ring slot by z mod 3, then y, then x
    always_comb
    begin
        ofs  = tap_ofs(cmd.tap);
        ax   = cmd.px - XW'(2) + XW'(ofs[5:4]);
        ay   = cmd.py - YW'(2) + YW'(ofs[3:2]);
        zsum = 3'(cmd.slot) + 3'd1 + 3'(ofs[1:0]);
        zs   = (zsum >= 3'd3) ? 2'(zsum - 3'd3) : zsum[1:0];
        if (cmd.mem_we)
            addr = ADDR_W'(cmd.slot) * ADDR_W'(PLANE_CELLS)
                 + ADDR_W'(cmd.py) * ADDR_W'(MAX_SIZE_X) + ADDR_W'(cmd.px);
        else
            addr = ADDR_W'(zs) * ADDR_W'(PLANE_CELLS)
                 + ADDR_W'(ay) * ADDR_W'(MAX_SIZE_X) + ADDR_W'(ax);
    end

    scs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RAM_DEPTH)) u_ram_u (
        .clk(clk), .we(cmd.mem_we), .re(cmd.mem_re), .addr(addr),
        .wdata(u_sample), .rdata(rd_u)
    );
    scs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RAM_DEPTH)) u_ram_v (
        .clk(clk), .we(cmd.mem_we), .re(cmd.mem_re), .addr(addr),
        .wdata(v_sample), .rdata(rd_v)
    );
    scs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RAM_DEPTH)) u_ram_w (
        .clk(clk), .we(cmd.mem_we), .re(cmd.mem_re), .addr(addr),
        .wdata(w_sample), .rdata(rd_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_dx_reg     <= INV_W'(65536);
            inv_dy_reg     <= INV_W'(65536);
            inv_dz_reg     <= INV_W'(65536);
            cap_en_reg     <= 1'b0;
            taps_ready_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_INV_DX: inv_dx_reg <= cfg_data[INV_W-1:0];
                    CFG_INV_DY: inv_dy_reg <= cfg_data[INV_W-1:0];
                    CFG_INV_DZ: inv_dz_reg <= cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end
            cap_en_reg     <= cmd.mem_re;
            taps_ready_reg <= cap_en_reg && (cap_tap_reg == TAP_W'(NTAP - 1));
        end
    end

    assign stat.taps_ready = taps_ready_reg;

    // operand pairs for each of the nine flux terms
    always_comb
    begin
        case (cmd.term)
            4'd0:
            begin
                a1 = tu_reg[T_XP]; a2 = tu_reg[T_C];  b1 = tu_reg[T_XP]; b2 = tu_reg[T_C];
                c1 = tu_reg[T_C];  c2 = tu_reg[T_XM]; d1 = tu_reg[T_C];  d2 = tu_reg[T_XM];
            end
            4'd1:
            begin
                a1 = tu_reg[T_YP]; a2 = tu_reg[T_C];  b1 = tv_reg[T_YP]; b2 = tv_reg[T_XM_YP];
                c1 = tu_reg[T_C];  c2 = tu_reg[T_YM]; d1 = tv_reg[T_C];  d2 = tv_reg[T_XM];
            end
            4'd2:
            begin
                a1 = tu_reg[T_ZP]; a2 = tu_reg[T_C];  b1 = tw_reg[T_ZP]; b2 = tw_reg[T_XM_ZP];
                c1 = tu_reg[T_C];  c2 = tu_reg[T_ZM]; d1 = tw_reg[T_C];  d2 = tw_reg[T_XM];
            end
            4'd3:
            begin
                a1 = tv_reg[T_XP]; a2 = tv_reg[T_C];  b1 = tu_reg[T_XP]; b2 = tu_reg[T_XP_YM];
                c1 = tv_reg[T_C];  c2 = tv_reg[T_XM]; d1 = tu_reg[T_C];  d2 = tu_reg[T_YM];
            end
            4'd4:
            begin
                a1 = tv_reg[T_YP]; a2 = tv_reg[T_C];  b1 = tv_reg[T_YP]; b2 = tv_reg[T_C];
                c1 = tv_reg[T_C];  c2 = tv_reg[T_YM]; d1 = tv_reg[T_C];  d2 = tv_reg[T_YM];
            end
            4'd5:
            begin
                a1 = tv_reg[T_ZP]; a2 = tv_reg[T_C];  b1 = tw_reg[T_ZP]; b2 = tw_reg[T_YM_ZP];
                c1 = tv_reg[T_C];  c2 = tv_reg[T_ZM]; d1 = tw_reg[T_C];  d2 = tw_reg[T_YM];
            end
            4'd6:
            begin
                a1 = tw_reg[T_XP]; a2 = tw_reg[T_C];  b1 = tu_reg[T_XP]; b2 = tu_reg[T_XP_ZM];
                c1 = tw_reg[T_C];  c2 = tw_reg[T_XM]; d1 = tu_reg[T_C];  d2 = tu_reg[T_ZM];
            end
            4'd7:
            begin
                a1 = tw_reg[T_YP]; a2 = tw_reg[T_C];  b1 = tv_reg[T_YP]; b2 = tv_reg[T_YP_ZM];
                c1 = tw_reg[T_C];  c2 = tw_reg[T_YM]; d1 = tv_reg[T_C];  d2 = tv_reg[T_ZM];
            end
            default:
            begin
                a1 = tw_reg[T_ZP]; a2 = tw_reg[T_C];  b1 = tw_reg[T_ZP]; b2 = tw_reg[T_C];
                c1 = tw_reg[T_C];  c2 = tw_reg[T_ZM]; d1 = tw_reg[T_C];  d2 = tw_reg[T_ZM];
            end
        endcase
    end

    always_comb
    begin
        case (cmd.axis)
            AX_X:    inv_sel = inv_dx_reg;
            AX_Y:    inv_sel = inv_dy_reg;
            default: inv_sel = inv_dz_reg;
        endcase
        diff    = WIDE_W'(p1_reg) - WIDE_W'(p2_reg);
        diff_sh = diff >>> SHIFT_DIFF;
        q_sh    = WIDE_W'(q_reg) >>> SHIFT_SCALE;
        scaled  = sat_wide(q_sh);
        acc_next = ((cmd.axis == AX_X) ? ACC_W'(0) : acc_reg) + ACC_W'(scaled);
    end

    always_ff @(posedge clk)
    begin
        cap_tap_reg <= cmd.tap;
        if (cap_en_reg)
        begin
            tu_reg[cap_tap_reg] <= rd_u;
            tv_reg[cap_tap_reg] <= rd_v;
            tw_reg[cap_tap_reg] <= rd_w;
        end
        case (cmd.phase)
            PH_SUM:
            begin
                s1_reg <= sat_add(a1, a2);
                s2_reg <= sat_add(b1, b2);
                s3_reg <= sat_add(c1, c2);
                s4_reg <= sat_add(d1, d2);
            end
            PH_MUL1:  p1_reg <= s1_reg * s2_reg;
            PH_MUL2:  p2_reg <= s3_reg * s4_reg;
            PH_DIFF:  t_reg  <= sat_wide(diff_sh);
            PH_SCALE: q_reg  <= t_reg * $signed({1'b0, inv_sel});
            PH_ACC:
            begin
                acc_reg <= acc_next;
                if (cmd.axis == AX_Z)
                begin
                    case (cmd.grp)
                        GRP_U:   res_u_reg <= sat_acc(acc_next);
                        GRP_V:   res_v_reg <= sat_acc(acc_next);
                        default: res_w_reg <= sat_acc(acc_next);
                    endcase
                end
            end
            default: ;
        endcase
        if (cmd.out_load)
        begin
            conv_u_reg <= res_u_reg;
            conv_v_reg <= res_v_reg;
            conv_w_reg <= res_w_reg;
        end
    end

    assign conv_u = conv_u_reg;
    assign conv_v = conv_v_reg;
    assign conv_w = conv_w_reg;

endmodule

`default_nettype wire

// ===== rtl/core/staggered_convection_stencil_top.sv =====
// Boundary cell: taken with no result; the next item can be taken the cycle after.
// Interior cell: 13 store reads, tap capture, 9 terms of 6 steps on one shared term
// unit, then the result load once the output is free; ready again right after the
// load, so no new item is taken while an interior item is in work.
// Result sits in an output register; the next item is taken while it waits.
// Reset clears position, sets sizes to 64 and inverse spacings to 65536; plane stores are not cleared.
// Depends on scs_pkg, scs_ctrl, scs_dpath, scs_ram.
`default_nettype none

module staggered_convection_stencil_top
    import scs_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] u_sample,
    input  wire logic signed [DATA_WIDTH-1:0] v_sample,
    input  wire logic signed [DATA_WIDTH-1:0] w_sample,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0]      conv_u,
    output logic signed [DATA_WIDTH-1:0]      conv_v,
    output logic signed [DATA_WIDTH-1:0]      conv_w,
    output logic [XW-1:0]                     cell_x,
    output logic [YW-1:0]                     cell_y,
    output logic [ZW-1:0]                     cell_z,
    output logic                              last_cell,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IW-1:0]            cfg_index,
    input  wire logic [CFG_W-1:0]             cfg_data
);

    scs_cmd_t  cmd;
    scs_stat_t stat;

    scs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .stat(stat), .cmd(cmd),
        .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z), .last_cell(last_cell)
    );

    scs_dpath u_dpath (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .u_sample(u_sample), .v_sample(v_sample), .w_sample(w_sample),
        .cmd(cmd), .stat(stat),
        .conv_u(conv_u), .conv_v(conv_v), .conv_w(conv_w)
    );

endmodule

`default_nettype wire
